>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPLIES_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/tlfc_pkg.sv
// ----------------------------------------------------------------------------
// tlfc_pkg
// Shared types and constants of the two-level LRU frame cache tag engine.
// ----------------------------------------------------------------------------
package tlfc_pkg;

	localparam int MEDIA_SLOTS_DEF = 8;
	localparam int FRAME_SLOTS_DEF = 32;

	localparam int ID_W   = 32;
	localparam int MS_W   = 3;
	localparam int NUM_W  = 64;
	localparam int GEO_W  = 44;
	localparam int TS_W   = 48;
	localparam int IN_W   = 152;
	localparam int OUT_W  = 56;

	typedef enum logic [1:0] {
		REQ_ACQUIRE = 2'd0,
		REQ_LOOKUP  = 2'd1,
		REQ_PUT     = 2'd2,
		REQ_CLEAR   = 2'd3
	} req_t;

	localparam logic [1:0] STAT_MISS = 2'd0;
	localparam logic [1:0] STAT_HIT  = 2'd1;
	localparam logic [1:0] STAT_NEW  = 2'd2;

	localparam logic CFG_MEDIA_CAP = 1'b0;
	localparam logic CFG_FRAME_CAP = 1'b1;

endpackage

>>> hdl/tlfc_ram.sv
// ----------------------------------------------------------------------------
// tlfc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tlfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/two_level_lru_frame_cache_tags_core.sv
// ----------------------------------------------------------------------------
// two_level_lru_frame_cache_tags_core
// Tag and LRU replacement engine for a media table and a frame table.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel, one word per request; each request gives
// exactly one result word on the m_ channel. The user writes capacities through
// cfg_we/cfg_index/cfg_wdata while the block is idle; the block does not enforce it.
// Each table lives in a RAM with a registered read; valid bits and
// occupancy counts sit in flops. Recency is kept as a write stamp per entry.
// Flow, one request at a time:
//   acquire hit or failed open: one media table scan
//   acquire insert: on a full table, per eviction, a purge scan of the frame
//     table for the oldest entry's frames, then a rescan of the media table
//   clear, or frame request on an unused media slot: straight to the result
//   lookup/put: one frame table scan, then a read and restamp of the entry on
//     a hit, or one more frame table scan per eviction
// The scans, one entry per cycle through the RAM read port, set the rate.
// Reset empties both tables and sets the capacities to 8 media and 32 frame entries.
// While the result word is not taken the next request may still be accepted
// and worked on; it then waits in its final state for the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_level_lru_frame_cache_tags_core #(
	parameter int MEDIA_SLOTS = tlfc_pkg::MEDIA_SLOTS_DEF,
	parameter int FRAME_SLOTS = tlfc_pkg::FRAME_SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// media_id, open_ok, media_slot, frame_number, approximate, interactive,
	// width, height, stride, zero pad
	input  logic [tlfc_pkg::IN_W-1:0] s_tdata,
	// req_type
	input  logic [1:0]                s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// media_slot_out, frame_slot_out, was_approximate, width_out,
	// height_out, stride_out, zero pad
	output logic [tlfc_pkg::OUT_W-1:0] m_tdata,
	// status
	output logic [1:0]                m_tuser,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [5:0]                cfg_wdata
);

	localparam int MIW  = (MEDIA_SLOTS > 1) ? $clog2(MEDIA_SLOTS) : 1;
	localparam int FIW  = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
	localparam int MCW  = $clog2(MEDIA_SLOTS + 1);
	localparam int FCW  = $clog2(FRAME_SLOTS + 1);
	localparam int OCW  = (MIW > tlfc_pkg::MS_W) ? MIW : tlfc_pkg::MS_W;
	localparam int MREC_W = tlfc_pkg::ID_W + tlfc_pkg::TS_W;
	localparam int F_NUM_LO = tlfc_pkg::MS_W;
	localparam int F_APX    = F_NUM_LO + tlfc_pkg::NUM_W;
	localparam int F_GEO_LO = F_APX + 1;
	localparam int F_TS_LO  = F_GEO_LO + tlfc_pkg::GEO_W;
	localparam int FREC_W   = F_TS_LO + tlfc_pkg::TS_W;
	localparam logic [MIW-1:0] M_LAST = MIW'(MEDIA_SLOTS - 1);
	localparam logic [FIW-1:0] F_LAST = FIW'(FRAME_SLOTS - 1);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_M_SCAN = 8'b0000_0010,
		ST_M_EVAL = 8'b0000_0100,
		ST_F_SCAN = 8'b0000_1000,
		ST_F_EVAL = 8'b0001_0000,
		ST_F_RD   = 8'b0010_0000,
		ST_F_WR   = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q;

	tlfc_pkg::req_t              req_q;
	logic [tlfc_pkg::ID_W-1:0]   id_q;
	logic                        open_ok_q;
	logic [tlfc_pkg::MS_W-1:0]   ms_q;
	logic [tlfc_pkg::NUM_W-1:0]  num_q;
	logic                        apx_q;
	logic                        inter_q;
	logic [tlfc_pkg::GEO_W-1:0]  geo_q;

	logic [MEDIA_SLOTS-1:0] mvalid_q;
	logic [FRAME_SLOTS-1:0] fvalid_q;
	logic [MCW-1:0]         mcnt_q;
	logic [FCW-1:0]         fcnt_q;
	logic [3:0]             mcap_q;
	logic [5:0]             fcap_q;
	logic [tlfc_pkg::TS_W-1:0] now_q;

	logic           mrun_q, mpend_s1;
	logic [MIW-1:0] midx_q, midx_s1;
	logic           frun_q, fpend_s1;
	logic [FIW-1:0] fidx_q, fidx_s1;
	logic           purge_q;
	logic [MIW-1:0] victim_q;

	logic           mhit_q, mold_q;
	logic [MIW-1:0] mhit_idx_q, mold_idx_q;
	logic [tlfc_pkg::TS_W-1:0] mold_ts_q;
	logic           f0_q, f1_q, fold_q;
	logic [FIW-1:0] f0_idx_q, f1_idx_q, fold_idx_q, fsel_q;
	logic [tlfc_pkg::TS_W-1:0] fold_ts_q;

	logic [1:0]                 res_status_q;
	logic [2:0]                 res_mslot_q;
	logic [4:0]                 res_fslot_q;
	logic                       res_apx_q;
	logic [tlfc_pkg::GEO_W-1:0] res_geo_q;

	logic                       m_tvalid_q;
	logic [tlfc_pkg::OUT_W-1:0] m_tdata_q;
	logic [1:0]                 m_tuser_q;

	logic              m_we;
	logic [MIW-1:0]    m_waddr;
	logic [MREC_W-1:0] m_wdata, m_rdata;
	logic              f_we;
	logic [FIW-1:0]    f_waddr, f_raddr;
	logic [FREC_W-1:0] f_wdata, f_rdata;

	logic [tlfc_pkg::ID_W-1:0]  m_tag_rd;
	logic [tlfc_pkg::TS_W-1:0]  m_ts_rd, f_ts_rd;
	logic [tlfc_pkg::MS_W-1:0]  f_own_rd;
	logic [tlfc_pkg::NUM_W-1:0] f_num_rd;
	logic                       f_apx_rd;
	logic [tlfc_pkg::GEO_W-1:0] f_geo_rd;

	logic [MIW-1:0] mfree_idx;
	logic [FIW-1:0] ffree_idx;
	logic [MCW-1:0] mcap_eff;
	logic [FCW-1:0] fcap_eff;
	logic           s_ms_ok;
	logic           m_evict, m_ins;
	logic           f_key_hit, f_evict, f_ins;
	logic [FIW-1:0] f_key_idx;
	logic           lk_hit;
	logic [FIW-1:0] lk_idx;
	logic [tlfc_pkg::MS_W-1:0] s_ms;

	assign m_tag_rd = m_rdata[tlfc_pkg::ID_W-1:0];
	assign m_ts_rd  = m_rdata[MREC_W-1:tlfc_pkg::ID_W];
	assign f_own_rd = f_rdata[tlfc_pkg::MS_W-1:0];
	assign f_num_rd = f_rdata[F_APX-1:F_NUM_LO];
	assign f_apx_rd = f_rdata[F_APX];
	assign f_geo_rd = f_rdata[F_TS_LO-1:F_GEO_LO];
	assign f_ts_rd  = f_rdata[FREC_W-1:F_TS_LO];

	assign s_ms    = s_tdata[35:33];
	assign s_ms_ok = (32'(s_ms) < 32'(MEDIA_SLOTS)) && mvalid_q[MIW'(s_ms)];

	always_comb begin
		mfree_idx = '0;
		for (int i = MEDIA_SLOTS - 1; i >= 0; i--) begin
			if (!mvalid_q[i]) begin
				mfree_idx = MIW'(i);
			end
		end
		ffree_idx = '0;
		for (int i = FRAME_SLOTS - 1; i >= 0; i--) begin
			if (!fvalid_q[i]) begin
				ffree_idx = FIW'(i);
			end
		end
	end

	always_comb begin
		if (mcap_q == '0) begin
			mcap_eff = MCW'(1);
		end else if (32'(mcap_q) > 32'(MEDIA_SLOTS)) begin
			mcap_eff = MCW'(MEDIA_SLOTS);
		end else begin
			mcap_eff = MCW'(mcap_q);
		end
		if (fcap_q == '0) begin
			fcap_eff = FCW'(1);
		end else if (32'(fcap_q) > 32'(FRAME_SLOTS)) begin
			fcap_eff = FCW'(FRAME_SLOTS);
		end else begin
			fcap_eff = FCW'(fcap_q);
		end
	end

	assign m_evict   = !mhit_q && open_ok_q && (mcnt_q >= mcap_eff);
	assign m_ins     = !mhit_q && open_ok_q && (mcnt_q < mcap_eff);
	assign f_key_hit = apx_q ? f1_q : f0_q;
	assign f_key_idx = apx_q ? f1_idx_q : f0_idx_q;
	assign f_evict   = !f_key_hit && (fcnt_q >= fcap_eff);
	assign f_ins     = !f_key_hit && (fcnt_q < fcap_eff);
	assign lk_hit    = f0_q || (inter_q && f1_q);
	assign lk_idx    = f0_q ? f0_idx_q : f1_idx_q;

	always_comb begin
		m_we    = 1'b0;
		m_waddr = mhit_q ? mhit_idx_q : mfree_idx;
		m_wdata = {now_q, id_q};
		f_we    = 1'b0;
		f_waddr = ffree_idx;
		f_wdata = {now_q, geo_q, apx_q, num_q, ms_q};
		f_raddr = fidx_q;
		case (state_q)
			ST_M_EVAL: begin
				m_we = mhit_q || m_ins;
			end
			ST_F_EVAL: begin
				f_we = (req_q == tlfc_pkg::REQ_PUT) && f_ins;
			end
			ST_F_RD: begin
				f_raddr = fsel_q;
			end
			ST_F_WR: begin
				f_we    = 1'b1;
				f_waddr = fsel_q;
				f_wdata = {now_q, f_rdata[F_TS_LO-1:0]};
			end
			default: begin
			end
		endcase
	end

	tlfc_ram #(
		.WIDTH(MREC_W),
		.DEPTH(MEDIA_SLOTS),
		.AW   (MIW)
	) u_media_ram (
		.clk  (clk),
		.we   (m_we),
		.waddr(m_waddr),
		.wdata(m_wdata),
		.raddr(midx_q),
		.rdata(m_rdata)
	);

	tlfc_ram #(
		.WIDTH(FREC_W),
		.DEPTH(FRAME_SLOTS),
		.AW   (FIW)
	) u_frame_ram (
		.clk  (clk),
		.we   (f_we),
		.waddr(f_waddr),
		.wdata(f_wdata),
		.raddr(f_raddr),
		.rdata(f_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mvalid_q   <= '0;
			fvalid_q   <= '0;
			mcnt_q     <= '0;
			fcnt_q     <= '0;
			mcap_q     <= 4'd8;
			fcap_q     <= 6'd32;
			now_q      <= '0;
			mrun_q     <= 1'b0;
			mpend_s1   <= 1'b0;
			midx_q     <= '0;
			frun_q     <= 1'b0;
			fpend_s1   <= 1'b0;
			fidx_q     <= '0;
			purge_q    <= 1'b0;
			mhit_q     <= 1'b0;
			mold_q     <= 1'b0;
			f0_q       <= 1'b0;
			f1_q       <= 1'b0;
			fold_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tlfc_pkg::CFG_MEDIA_CAP: mcap_q <= cfg_wdata[3:0];
					tlfc_pkg::CFG_FRAME_CAP: fcap_q <= cfg_wdata;
					default: begin
					end
				endcase
			end

			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end

			// media scan pipeline
			if (state_q == ST_M_SCAN) begin
				mpend_s1 <= mrun_q;
				midx_s1  <= midx_q;
				if (mrun_q) begin
					if (midx_q == M_LAST) begin
						mrun_q <= 1'b0;
					end else begin
						midx_q <= midx_q + 1'b1;
					end
				end
				if (mpend_s1 && mvalid_q[midx_s1]) begin
					if (m_tag_rd == id_q && !mhit_q) begin
						mhit_q     <= 1'b1;
						mhit_idx_q <= midx_s1;
					end
					if (!mold_q || m_ts_rd < mold_ts_q) begin
						mold_q     <= 1'b1;
						mold_idx_q <= midx_s1;
						mold_ts_q  <= m_ts_rd;
					end
				end
			end

			// frame scan pipeline
			if (state_q == ST_F_SCAN) begin
				fpend_s1 <= frun_q;
				fidx_s1  <= fidx_q;
				if (frun_q) begin
					if (fidx_q == F_LAST) begin
						frun_q <= 1'b0;
					end else begin
						fidx_q <= fidx_q + 1'b1;
					end
				end
				if (fpend_s1 && fvalid_q[fidx_s1]) begin
					if (purge_q) begin
						if (OCW'(f_own_rd) == OCW'(victim_q)) begin
							fvalid_q[fidx_s1] <= 1'b0;
							fcnt_q            <= fcnt_q - 1'b1;
						end
					end else begin
						if (f_own_rd == ms_q && f_num_rd == num_q) begin
							if (f_apx_rd && !f1_q) begin
								f1_q     <= 1'b1;
								f1_idx_q <= fidx_s1;
							end
							if (!f_apx_rd && !f0_q) begin
								f0_q     <= 1'b1;
								f0_idx_q <= fidx_s1;
							end
						end
						if (!fold_q || f_ts_rd < fold_ts_q) begin
							fold_q     <= 1'b1;
							fold_idx_q <= fidx_s1;
							fold_ts_q  <= f_ts_rd;
						end
					end
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						req_q        <= tlfc_pkg::req_t'(s_tuser);
						id_q         <= s_tdata[31:0];
						open_ok_q    <= s_tdata[32];
						ms_q         <= s_ms;
						num_q        <= s_tdata[99:36];
						apx_q        <= s_tdata[100];
						inter_q      <= s_tdata[101];
						geo_q        <= s_tdata[145:102];
						res_status_q <= tlfc_pkg::STAT_MISS;
						res_mslot_q  <= '0;
						res_fslot_q  <= '0;
						res_apx_q    <= 1'b0;
						res_geo_q    <= '0;
						case (tlfc_pkg::req_t'(s_tuser))
							tlfc_pkg::REQ_ACQUIRE: begin
								state_q  <= ST_M_SCAN;
								mrun_q   <= 1'b1;
								midx_q   <= '0;
								mpend_s1 <= 1'b0;
								mhit_q   <= 1'b0;
								mold_q   <= 1'b0;
							end
							tlfc_pkg::REQ_CLEAR: begin
								mvalid_q <= '0;
								fvalid_q <= '0;
								mcnt_q   <= '0;
								fcnt_q   <= '0;
								state_q  <= ST_DONE;
							end
							default: begin
								if (s_ms_ok) begin
									state_q  <= ST_F_SCAN;
									purge_q  <= 1'b0;
									frun_q   <= 1'b1;
									fidx_q   <= '0;
									fpend_s1 <= 1'b0;
									f0_q     <= 1'b0;
									f1_q     <= 1'b0;
									fold_q   <= 1'b0;
								end else begin
									state_q <= ST_DONE;
								end
							end
						endcase
					end
				end
				ST_M_SCAN: begin
					if (mpend_s1 && midx_s1 == M_LAST) begin
						state_q <= ST_M_EVAL;
					end
				end
				ST_M_EVAL: begin
					if (mhit_q) begin
						res_status_q <= tlfc_pkg::STAT_HIT;
						res_mslot_q  <= 3'(mhit_idx_q);
						now_q        <= now_q + 1'b1;
						state_q      <= ST_DONE;
					end else if (m_evict) begin
						// drop the oldest media entry, then purge its frames
						mvalid_q[mold_idx_q] <= 1'b0;
						mcnt_q   <= mcnt_q - 1'b1;
						victim_q <= mold_idx_q;
						purge_q  <= 1'b1;
						frun_q   <= 1'b1;
						fidx_q   <= '0;
						fpend_s1 <= 1'b0;
						state_q  <= ST_F_SCAN;
					end else if (m_ins) begin
						mvalid_q[mfree_idx] <= 1'b1;
						mcnt_q       <= mcnt_q + 1'b1;
						res_status_q <= tlfc_pkg::STAT_NEW;
						res_mslot_q  <= 3'(mfree_idx);
						now_q        <= now_q + 1'b1;
						state_q      <= ST_DONE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_F_SCAN: begin
					if (fpend_s1 && fidx_s1 == F_LAST) begin
						if (purge_q) begin
							state_q  <= ST_M_SCAN;
							mrun_q   <= 1'b1;
							midx_q   <= '0;
							mpend_s1 <= 1'b0;
							mhit_q   <= 1'b0;
							mold_q   <= 1'b0;
						end else begin
							state_q <= ST_F_EVAL;
						end
					end
				end
				ST_F_EVAL: begin
					if (req_q == tlfc_pkg::REQ_LOOKUP) begin
						if (lk_hit) begin
							fsel_q       <= lk_idx;
							res_status_q <= tlfc_pkg::STAT_HIT;
							res_fslot_q  <= 5'(lk_idx);
							res_apx_q    <= !f0_q;
							state_q      <= ST_F_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (f_key_hit) begin
						fsel_q       <= f_key_idx;
						res_status_q <= tlfc_pkg::STAT_HIT;
						res_fslot_q  <= 5'(f_key_idx);
						state_q      <= ST_F_RD;
					end else if (f_evict) begin
						fvalid_q[fold_idx_q] <= 1'b0;
						fcnt_q   <= fcnt_q - 1'b1;
						frun_q   <= 1'b1;
						fidx_q   <= '0;
						fpend_s1 <= 1'b0;
						f0_q     <= 1'b0;
						f1_q     <= 1'b0;
						fold_q   <= 1'b0;
						state_q  <= ST_F_SCAN;
					end else begin
						fvalid_q[ffree_idx] <= 1'b1;
						fcnt_q       <= fcnt_q + 1'b1;
						res_status_q <= tlfc_pkg::STAT_NEW;
						res_fslot_q  <= 5'(ffree_idx);
						now_q        <= now_q + 1'b1;
						state_q      <= ST_DONE;
					end
				end
				ST_F_RD: begin
					state_q <= ST_F_WR;
				end
				ST_F_WR: begin
					if (req_q == tlfc_pkg::REQ_LOOKUP) begin
						res_geo_q <= f_geo_rd;
					end
					now_q   <= now_q + 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= res_status_q;
						m_tdata_q  <= {3'b0, res_geo_q, res_apx_q, res_fslot_q, res_mslot_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`ASSERT_ALWAYS(a_mcnt_match, clk, arst_n, 32'(mcnt_q) == $countones(mvalid_q))
	`ASSERT_ALWAYS(a_fcnt_match, clk, arst_n, 32'(fcnt_q) == $countones(fvalid_q))
	`ASSERT_IMPLIES_NEXT(a_done_hold, clk, arst_n, (state_q == ST_DONE) && m_tvalid_q && !m_tready, state_q == ST_DONE)

endmodule
